### design/swdh_pkg.sv
package swdh_pkg;

    localparam int unsigned PHASE_W = 4;
    localparam int unsigned CNT_W   = 9;
    localparam int unsigned DATA_W  = 32;

    // func codes
    localparam logic [1:0] FUNC_TICK       = 2'd0;
    localparam logic [1:0] FUNC_READ       = 2'd1;
    localparam logic [1:0] FUNC_WRITE      = 2'd2;
    localparam logic [1:0] FUNC_LINE_RESET = 2'd3;

    // sequencer phases
    localparam logic [PHASE_W-1:0] PH_IDLE       = 4'd0;
    localparam logic [PHASE_W-1:0] PH_RST_ONES_A = 4'd1;
    localparam logic [PHASE_W-1:0] PH_RST_KEY    = 4'd2;
    localparam logic [PHASE_W-1:0] PH_RST_ONES_B = 4'd3;
    localparam logic [PHASE_W-1:0] PH_RST_ZERO   = 4'd4;
    localparam logic [PHASE_W-1:0] PH_REQ        = 4'd5;
    localparam logic [PHASE_W-1:0] PH_TURN       = 4'd6;
    localparam logic [PHASE_W-1:0] PH_ACK        = 4'd7;
    localparam logic [PHASE_W-1:0] PH_TRAIL      = 4'd8;
    localparam logic [PHASE_W-1:0] PH_RDATA      = 4'd9;
    localparam logic [PHASE_W-1:0] PH_RPAR       = 4'd10;
    localparam logic [PHASE_W-1:0] PH_RTURN      = 4'd11;
    localparam logic [PHASE_W-1:0] PH_WTURN      = 4'd12;
    localparam logic [PHASE_W-1:0] PH_WDATA      = 4'd13;

    localparam logic [15:0] RESET_KEY = 16'hE79E;
    localparam logic [2:0]  ACK_OK    = 3'd1;

    typedef struct packed {
        logic              line_out;
        logic              line_drive;
        logic              clock_pulse;
        logic              busy;
        logic              done;
        logic [2:0]        ack;
        logic              parity_error;
        logic [DATA_W-1:0] read_data;
    } swdh_result_t;

    function automatic logic [CNT_W-1:0] phase_len(input logic [PHASE_W-1:0] ph);
        logic [CNT_W-1:0] len;
        unique case (ph)
            PH_RST_ONES_A: len = 9'd152;
            PH_RST_KEY:    len = 9'd16;
            PH_RST_ONES_B: len = 9'd150;
            PH_RST_ZERO:   len = 9'd2;
            PH_REQ:        len = 9'd8;
            PH_TURN:       len = 9'd1;
            PH_ACK:        len = 9'd3;
            PH_TRAIL:      len = 9'd1;
            PH_RDATA:      len = 9'd32;
            PH_RPAR:       len = 9'd1;
            PH_RTURN:      len = 9'd1;
            PH_WTURN:      len = 9'd1;
            PH_WDATA:      len = 9'd33;
            default:       len = 9'd0;
        endcase
        return len;
    endfunction

    // start, APnDP, RnW, A2, A3, parity, stop, park (lsb first)
    function automatic logic [7:0] build_request(input logic       port,
                                                 input logic [1:0] addr,
                                                 input logic       wr);
        logic rnw;
        logic par;
        rnw = ~wr;
        par = port ^ rnw ^ addr[0] ^ addr[1];
        return {1'b1, 1'b0, par, addr[1], addr[0], rnw, port, 1'b1};
    endfunction

endpackage

### design/swdh_bit_engine.sv
module swdh_bit_engine
    import swdh_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic              push_pull,
    input  logic [1:0]        func,
    input  logic              port_select,
    input  logic [1:0]        reg_addr,
    input  logic [DATA_W-1:0] write_data,
    input  logic              line_in,
    output swdh_result_t      res
);

    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               is_write_reg, is_write_next;
    logic [DATA_W:0]    shift_reg, shift_next;
    logic [2:0]         ack_reg, ack_next;
    logic               parity_reg, parity_next;
    logic [7:0]         req_reg, req_next;

    logic [CNT_W-1:0]   cnt_inc;
    logic               rel;
    logic               load_req;
    logic               ld_port;
    logic [1:0]         ld_addr;
    logic               ld_wr;
    logic [DATA_W-1:0]  ld_data;
    logic [DATA_W-1:0]  rd_word;

    always_comb
    begin
        phase_next    = phase_reg;
        cnt_next      = cnt_reg;
        is_write_next = is_write_reg;
        shift_next    = shift_reg;
        ack_next      = ack_reg;
        parity_next   = parity_reg;
        req_next      = req_reg;

        res           = '0;
        res.line_drive = 1'b1;
        rel           = 1'b0;
        load_req      = 1'b0;
        ld_port       = port_select;
        ld_addr       = reg_addr;
        ld_wr         = (func == FUNC_WRITE);
        ld_data       = write_data;
        rd_word       = shift_reg[DATA_W-1:0];
        cnt_inc       = cnt_reg + 9'd1;

        if (phase_reg == PH_IDLE)
        begin
            unique case (func)
                FUNC_READ, FUNC_WRITE: load_req = 1'b1;
                FUNC_LINE_RESET:
                begin
                    phase_next = PH_RST_ONES_A;
                    cnt_next   = '0;
                end
                default: ;
            endcase
        end
        else
        begin
            res.clock_pulse = 1'b1;
            unique case (phase_reg)
                PH_RST_ONES_A, PH_RST_ONES_B: res.line_out = 1'b1;
                PH_RST_KEY:  res.line_out = RESET_KEY[cnt_reg[3:0]];
                PH_RST_ZERO: res.line_out = 1'b0;
                PH_REQ:      res.line_out = req_reg[cnt_reg[2:0]];
                PH_ACK:
                begin
                    rel      = 1'b1;
                    ack_next = ack_reg | (3'(line_in) << cnt_reg[1:0]);
                end
                PH_RDATA:
                begin
                    rel                  = 1'b1;
                    rd_word[cnt_reg[4:0]] = rd_word[cnt_reg[4:0]] | line_in;
                    shift_next           = {shift_reg[DATA_W], rd_word};
                    parity_next          = parity_reg ^ line_in;
                end
                PH_RPAR:
                begin
                    rel         = 1'b1;
                    parity_next = parity_reg ^ line_in;
                end
                PH_WDATA:    res.line_out = shift_reg[cnt_reg[5:0]];
                default:     rel = 1'b1;
            endcase
            if (rel)
            begin
                res.line_out   = 1'b1;
                res.line_drive = ~push_pull;
            end

            cnt_next = cnt_inc;
            if (cnt_inc >= phase_len(phase_reg))
            begin
                cnt_next = '0;
                priority case (phase_reg)
                    PH_RST_ONES_A: phase_next = PH_RST_KEY;
                    PH_RST_KEY:    phase_next = PH_RST_ONES_B;
                    PH_RST_ONES_B: phase_next = PH_RST_ZERO;
                    PH_RST_ZERO:
                    begin
                        // follow the reset with a read of the DP ID register
                        load_req = 1'b1;
                        ld_port  = 1'b0;
                        ld_addr  = 2'd0;
                        ld_wr    = 1'b0;
                        ld_data  = '0;
                    end
                    PH_REQ:  phase_next = PH_TURN;
                    PH_TURN: phase_next = PH_ACK;
                    PH_ACK:
                    begin
                        if (ack_next == ACK_OK)
                            phase_next = is_write_reg ? PH_WTURN : PH_RDATA;
                        else
                            phase_next = PH_TRAIL;
                    end
                    PH_RDATA: phase_next = PH_RPAR;
                    PH_RPAR:  phase_next = PH_RTURN;
                    PH_WTURN: phase_next = PH_WDATA;
                    PH_RTURN:
                    begin
                        res.done         = 1'b1;
                        res.ack          = ack_next;
                        res.parity_error = parity_next;
                        res.read_data    = shift_next[DATA_W-1:0];
                        phase_next       = PH_IDLE;
                    end
                    default:
                    begin
                        res.done   = 1'b1;
                        res.ack    = ack_next;
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end

        if (load_req)
        begin
            req_next      = build_request(ld_port, ld_addr, ld_wr);
            is_write_next = ld_wr;
            shift_next    = ld_wr ? {^ld_data, ld_data} : '0;
            ack_next      = '0;
            parity_next   = 1'b0;
            cnt_next      = '0;
            phase_next    = PH_REQ;
        end

        res.busy = (phase_next != PH_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            cnt_reg      <= '0;
            is_write_reg <= 1'b0;
            shift_reg    <= '0;
            ack_reg      <= '0;
            parity_reg   <= 1'b0;
            req_reg      <= '0;
        end
        else if (step)
        begin
            phase_reg    <= phase_next;
            cnt_reg      <= cnt_next;
            is_write_reg <= is_write_next;
            shift_reg    <= shift_next;
            ack_reg      <= ack_next;
            parity_reg   <= parity_next;
            req_reg      <= req_next;
        end
    end

    a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        step && res.done |=> phase_reg == PH_IDLE)
        else $error("completed transaction did not return to idle");

    a_ack_count: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_ACK |-> cnt_reg < 9'd3)
        else $error("ack bit count out of range");

    a_idle_no_clock: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_IDLE |-> !res.clock_pulse && !res.done)
        else $error("clock or done issued while idle");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != PH_IDLE |-> cnt_reg < phase_len(phase_reg))
        else $error("bit count past phase length");

endmodule

### design/swd_host_transaction_engine_core.sv
// Channel   Signals                                            Handshake
// input     func port_select reg_addr write_data line_in       in_valid / in_stall
// result    line_out line_drive clock_pulse busy_res done_res  out_valid / out_stall
//           ack parity_error read_data
// config    cfg_data (push_pull_mode)                          cfg_valid / cfg_ready
//
// One item per clock unless stalled: the bit sequencer advances one bit period
// per item and its result lands in the output register on the same edge.
// Throughput is set by the single output register; an item is taken whenever
// that register is empty or being drained.
// Reset clears the sequencer to idle and push_pull_mode to 0.
// A stall on the result side holds the output register and stalls the input.
module swd_host_transaction_engine_core
    import swdh_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        func,
    input  logic              port_select,
    input  logic [1:0]        reg_addr,
    input  logic [DATA_W-1:0] write_data,
    input  logic              line_in,

    output logic              out_valid,
    input  logic              out_stall,
    output logic              line_out,
    output logic              line_drive,
    output logic              clock_pulse,
    output logic              busy_res,
    output logic              done_res,
    output logic [2:0]        ack,
    output logic              parity_error,
    output logic [DATA_W-1:0] read_data,

    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_data
);

    logic         push_pull_reg;
    logic         out_valid_reg;
    swdh_result_t res_reg;
    swdh_result_t res;
    logic         step;

    assign in_stall  = out_valid_reg & out_stall;
    assign step      = in_valid & ~in_stall;
    assign cfg_ready = 1'b1;

    swdh_bit_engine u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .push_pull   (push_pull_reg),
        .func        (func),
        .port_select (port_select),
        .reg_addr    (reg_addr),
        .write_data  (write_data),
        .line_in     (line_in),
        .res         (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push_pull_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                push_pull_reg <= cfg_data;
            if (step)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
            res_reg <= res;
    end

    assign out_valid    = out_valid_reg;
    assign line_out     = res_reg.line_out;
    assign line_drive   = res_reg.line_drive;
    assign clock_pulse  = res_reg.clock_pulse;
    assign busy_res     = res_reg.busy;
    assign done_res     = res_reg.done;
    assign ack          = res_reg.ack;
    assign parity_error = res_reg.parity_error;
    assign read_data    = res_reg.read_data;

    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> out_valid)
        else $error("accepted item produced no result");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |-> in_stall)
        else $error("input taken while result waits");

    a_cfg_update: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |=> push_pull_reg == $past(cfg_data))
        else $error("config write lost");

endmodule

### sim/swd_host_transaction_engine_core_tb.sv
module swd_host_transaction_engine_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import swdh_pkg::*;

    localparam int CYCLE_LIMIT     = 100000;
    localparam int LINE_RESET_BITS = 320;   // 152 ones, 16 key bits, 150 ones, 2 zeros
    localparam int IDLE_PCT        = 21;

    typedef struct packed {
        logic [1:0]        func;
        logic              port;
        logic [1:0]        addr;
        logic [DATA_W-1:0] wdata;
        logic              lin;
    } swd_stim_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [1:0]        func = FUNC_TICK;
    logic              port_select = 1'b0;
    logic [1:0]        reg_addr = 2'd0;
    logic [DATA_W-1:0] write_data = '0;
    logic              line_in = 1'b0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic              line_out;
    logic              line_drive;
    logic              clock_pulse;
    logic              busy_res;
    logic              done_res;
    logic [2:0]        ack;
    logic              parity_error;
    logic [DATA_W-1:0] read_data;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic              cfg_data = 1'b0;

    swd_stim_t    bit_items[$];
    swd_stim_t    cur_item;
    swdh_result_t predicted_bits[$];

    int cycle_no = 0;
    int items_queued = 0;
    int idle_ticks = 0;
    int results_checked = 0;
    int fail_count = 0;
    int done_cnt = 0;
    int ok_cnt = 0;
    int perr_cnt = 0;
    logic quiet;

    // sequencer mirror
    logic                pp_mode = 1'b0;
    logic [PHASE_W-1:0]  seq_phase = PH_IDLE;
    logic [CNT_W-1:0]    seq_cnt = '0;
    logic                seq_wr = 1'b0;
    logic [DATA_W:0]     seq_shift = '0;
    logic [2:0]          seq_ack = '0;
    logic                seq_par = 1'b0;
    logic [7:0]          req_byte = '0;

    swd_host_transaction_engine_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .func         (func),
        .port_select  (port_select),
        .reg_addr     (reg_addr),
        .write_data   (write_data),
        .line_in      (line_in),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .line_out     (line_out),
        .line_drive   (line_drive),
        .clock_pulse  (clock_pulse),
        .busy_res     (busy_res),
        .done_res     (done_res),
        .ack          (ack),
        .parity_error (parity_error),
        .read_data    (read_data),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    // one stretch mid-run with no gaps on either side
    assign quiet = (cycle_no >= 1000) && (cycle_no < 1600);

    function automatic int bits_in(input logic [PHASE_W-1:0] ph);
        case (ph)
            PH_RST_ONES_A: return 152;
            PH_RST_KEY:    return 16;
            PH_RST_ONES_B: return 150;
            PH_RST_ZERO:   return 2;
            PH_REQ:        return 8;
            PH_TURN:       return 1;
            PH_ACK:        return 3;
            PH_TRAIL:      return 1;
            PH_RDATA:      return 32;
            PH_RPAR:       return 1;
            PH_RTURN:      return 1;
            PH_WTURN:      return 1;
            PH_WDATA:      return 33;
            default:       return 0;
        endcase
    endfunction

    function automatic void load_request(input logic port, input logic [1:0] addr,
                                         input logic wr, input logic [DATA_W-1:0] data);
        logic rnw;
        rnw = ~wr;
        // lsb first: start, APnDP, RnW, A2, A3, parity, stop, park
        req_byte = {1'b1, 1'b0, port ^ rnw ^ addr[0] ^ addr[1], addr[1], addr[0], rnw, port,
                    1'b1};
        seq_wr = wr;
        seq_shift = wr ? {^data, data} : '0;
        seq_ack = '0;
        seq_par = 1'b0;
        seq_cnt = '0;
        seq_phase = PH_REQ;
    endfunction

    function automatic swdh_result_t swd_next_bit(input swd_stim_t it);
        swdh_result_t r;
        logic released;
        r = '0;
        r.line_drive = 1'b1;
        released = 1'b0;
        if (seq_phase == PH_IDLE) begin
            if (it.func == FUNC_READ || it.func == FUNC_WRITE)
                load_request(it.port, it.addr, it.func == FUNC_WRITE, it.wdata);
            else if (it.func == FUNC_LINE_RESET) begin
                seq_phase = PH_RST_ONES_A;
                seq_cnt = '0;
            end
        end else begin
            r.clock_pulse = 1'b1;
            case (seq_phase)
                PH_RST_ONES_A, PH_RST_ONES_B: r.line_out = 1'b1;
                PH_RST_KEY:  r.line_out = RESET_KEY[seq_cnt[3:0]];
                PH_RST_ZERO: r.line_out = 1'b0;
                PH_REQ:      r.line_out = req_byte[seq_cnt[2:0]];
                PH_ACK:
                begin
                    released = 1'b1;
                    seq_ack = seq_ack | (3'(it.lin) << seq_cnt[1:0]);
                end
                PH_RDATA:
                begin
                    released = 1'b1;
                    seq_shift[seq_cnt[4:0]] = seq_shift[seq_cnt[4:0]] | it.lin;
                    seq_par = seq_par ^ it.lin;
                end
                PH_RPAR:
                begin
                    released = 1'b1;
                    seq_par = seq_par ^ it.lin;
                end
                PH_WDATA:    r.line_out = seq_shift[seq_cnt[5:0]];
                default:     released = 1'b1;
            endcase
            if (released) begin
                r.line_out = 1'b1;
                r.line_drive = ~pp_mode;
            end
            seq_cnt = seq_cnt + 1'b1;
            if (seq_cnt >= bits_in(seq_phase)) begin
                seq_cnt = '0;
                case (seq_phase)
                    PH_RST_ONES_A: seq_phase = PH_RST_KEY;
                    PH_RST_KEY:    seq_phase = PH_RST_ONES_B;
                    PH_RST_ONES_B: seq_phase = PH_RST_ZERO;
                    PH_RST_ZERO:   load_request(1'b0, 2'd0, 1'b0, '0);  // ID register read
                    PH_REQ:        seq_phase = PH_TURN;
                    PH_TURN:       seq_phase = PH_ACK;
                    PH_ACK:
                        if (seq_ack == ACK_OK)
                            seq_phase = seq_wr ? PH_WTURN : PH_RDATA;
                        else
                            seq_phase = PH_TRAIL;
                    PH_RDATA:      seq_phase = PH_RPAR;
                    PH_RPAR:       seq_phase = PH_RTURN;
                    PH_WTURN:      seq_phase = PH_WDATA;
                    PH_RTURN:
                    begin
                        r.done = 1'b1;
                        r.ack = seq_ack;
                        r.parity_error = seq_par;
                        r.read_data = seq_shift[DATA_W-1:0];
                        seq_phase = PH_IDLE;
                    end
                    default:
                    begin
                        r.done = 1'b1;
                        r.ack = seq_ack;
                        seq_phase = PH_IDLE;
                    end
                endcase
            end
        end
        r.busy = seq_phase != PH_IDLE;
        return r;
    endfunction

    function automatic string fmt_bit(input swdh_result_t r);
        return $sformatf("lo=%b ld=%b clk=%b busy=%b done=%b ack=%0d perr=%b data=%h",
                         r.line_out, r.line_drive, r.clock_pulse, r.busy, r.done, r.ack,
                         r.parity_error, r.read_data);
    endfunction

    always @(posedge clk) begin
        cycle_no <= cycle_no + 1;
        if (cycle_no == CYCLE_LIMIT) begin
            $display("timeout: %0d of %0d items checked", results_checked, items_queued);
            $display("== FAIL ==");
            $finish;
        end
    end

    // driver
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall)
                predicted_bits.push_back(swd_next_bit(cur_item));
            if (!in_valid || !in_stall) begin
                if (bit_items.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
                    cur_item = bit_items.pop_front();
                    in_valid <= 1'b1;
                    func <= cur_item.func;
                    port_select <= cur_item.port;
                    reg_addr <= cur_item.addr;
                    write_data <= cur_item.wdata;
                    line_in <= cur_item.lin;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk) begin : mon
        swdh_result_t got;
        swdh_result_t want;
        string bad;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                got = {line_out, line_drive, clock_pulse, busy_res, done_res, ack,
                       parity_error, read_data};
                if (predicted_bits.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("ERROR unexpected item: %s", fmt_bit(got));
                end else begin
                    want = predicted_bits.pop_front();
                    bad = "";
                    if (got.line_out !== want.line_out)         bad = {bad, " line_out"};
                    if (got.line_drive !== want.line_drive)     bad = {bad, " line_drive"};
                    if (got.clock_pulse !== want.clock_pulse)   bad = {bad, " clock_pulse"};
                    if (got.busy !== want.busy)                 bad = {bad, " busy_res"};
                    if (got.done !== want.done)                 bad = {bad, " done_res"};
                    if (got.ack !== want.ack)                   bad = {bad, " ack"};
                    if (got.parity_error !== want.parity_error) bad = {bad, " parity_error"};
                    if (got.read_data !== want.read_data)       bad = {bad, " read_data"};
                    if (bad != "") begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("ERROR item %0d mismatch on%s", results_checked, bad);
                            $display("  expected %s", fmt_bit(want));
                            $display("  actual   %s", fmt_bit(got));
                        end
                    end
                    if (want.done) begin
                        done_cnt++;
                        if (want.ack == ACK_OK)
                            ok_cnt++;
                        if (want.parity_error)
                            perr_cnt++;
                    end
                    results_checked++;
                end
            end
            out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
        end
    end

    function automatic logic [DATA_W-1:0] random_word();
        int pick;
        pick = $urandom_range(9);
        if (pick == 0)
            return '0;
        if (pick == 1)
            return '1;
        return $urandom;
    endfunction

    task automatic push_item(input logic [1:0] f, input logic p, input logic [1:0] a,
                             input logic [DATA_W-1:0] d, input logic l);
        bit_items.push_back('{f, p, a, d, l});
        items_queued++;
    endtask

    // a bit period; some carry a start command that the busy engine must ignore
    task automatic push_tick(input logic l, input int noise_pct);
        logic [1:0] f;
        f = ($urandom_range(99) < noise_pct) ? 2'($urandom_range(3, 1)) : FUNC_TICK;
        push_item(f, 1'($urandom_range(1)), 2'($urandom_range(3)), $urandom, l);
    endtask

    // everything after the start item of a read or write
    task automatic push_frame(input logic wr, input logic [2:0] ack_bits, input int noise_pct);
        logic [DATA_W-1:0] rd;
        logic bad_par;
        rd = random_word();
        bad_par = ($urandom_range(3) == 0);
        repeat (9)
            push_tick(1'($urandom_range(1)), noise_pct);
        for (int i = 0; i < 3; i++)
            push_tick(ack_bits[i], noise_pct);
        if (ack_bits != ACK_OK) begin
            push_tick(1'($urandom_range(1)), noise_pct);
        end else if (wr) begin
            repeat (34)
                push_tick(1'($urandom_range(1)), noise_pct);
        end else begin
            for (int i = 0; i < DATA_W; i++)
                push_tick(rd[i], noise_pct);
            push_tick(^rd ^ bad_par, noise_pct);
            push_tick(1'($urandom_range(1)), noise_pct);
        end
    endtask

    task automatic push_line_reset(input logic [2:0] ack_bits);
        push_item(FUNC_LINE_RESET, 1'($urandom_range(1)), 2'($urandom_range(3)), $urandom,
                  1'($urandom_range(1)));
        repeat (LINE_RESET_BITS)
            push_tick(1'($urandom_range(1)), 8);
        push_frame(1'b0, ack_bits, 8);
    endtask

    task automatic push_random_access();
        logic [2:0] a;
        logic wr;
        a = ($urandom_range(99) < 70) ? ACK_OK : 3'($urandom_range(7));
        wr = 1'($urandom_range(1));
        if ($urandom_range(9) == 0) begin
            // tick while idle: no clock
            push_item(FUNC_TICK, 1'($urandom_range(1)), 2'($urandom_range(3)), $urandom,
                      1'($urandom_range(1)));
            idle_ticks++;
        end
        if ($urandom_range(49) == 0) begin
            push_line_reset(a);
        end else begin
            push_item(wr ? FUNC_WRITE : FUNC_READ, 1'($urandom_range(1)),
                      2'($urandom_range(3)), random_word(), 1'($urandom_range(1)));
            push_frame(wr, a, 8);
        end
    endtask

    task automatic wait_drained();
        while (results_checked != items_queued)
            @(posedge clk);
    endtask

    task automatic write_mode(input logic m);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= m;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        pp_mode = m;
    endtask

    task automatic run_phase(input int budget, input bit lead_reset, input bit hold_midway);
        int stop_at;
        stop_at = items_queued - idle_ticks + budget;
        if (lead_reset)
            push_line_reset(ACK_OK);
        while (items_queued - idle_ticks < stop_at) begin
            if (hold_midway && items_queued - idle_ticks >= stop_at - budget / 2) begin
                wait_drained();
                hold_midway = 1'b0;
            end
            push_random_access();
        end
        wait_drained();
    endtask

    initial begin
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;

        push_item(FUNC_TICK, 1'b0, 2'd0, '0, 1'b0);
        push_item(FUNC_TICK, 1'b1, 2'd3, '1, 1'b1);
        idle_ticks += 2;
        // heavy start-while-busy noise, ack of all ones
        push_item(FUNC_READ, 1'b1, 2'd3, '0, 1'b0);
        push_frame(1'b0, 3'b111, 50);
        push_item(FUNC_WRITE, 1'b0, 2'd0, '1, 1'b1);
        push_frame(1'b1, 3'b000, 0);
        wait_drained();

        write_mode(1'b1);
        run_phase(350, 1'b1, 1'b0);
        write_mode(1'b0);
        run_phase(350, 1'b0, 1'b1);
        write_mode(1'b1);
        run_phase(350, 1'b0, 1'b0);
        write_mode(1'b0);
        run_phase(350, 1'b0, 1'b0);
        repeat (4)
            @(posedge clk);

        $display("%0d bit periods checked in both drive modes, line resets included", 
                 results_checked);
        $display("%0d transactions done, %0d with ack OK, %0d read parity errors",
                 done_cnt, ok_cnt, perr_cnt);
        if (fail_count == 0 && predicted_bits.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
